// ===== design/bea_pkg.sv =====
// Shared types, codes and helper functions for the bitmap extent allocator.
`timescale 1ns / 1ps

package bea_pkg;

  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int WORD_BITS_DEF  = 64;

  // Widest bitmap word the datapath handles, and the widths derived from it.
  localparam int WORD_MAX = 64;
  localparam int OFF_W    = 7;
  localparam int HI_W     = 6;

  localparam int CFG_W    = 13;
  localparam int COUNT_W  = 13;

  typedef enum logic [1:0] {
    ACT_FORMAT = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_ALLOC  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2
  } status_t;

  typedef enum logic {
    CFG_DATA_BASE  = 1'b0,
    CFG_DEV_BLOCKS = 1'b1
  } cfg_index_t;

  // Result of one pass of the shared word unit.
  typedef struct packed {
    logic [WORD_MAX-1:0] merged;
    logic                hit;
    logic [HI_W-1:0]     hi;
  } unit_out_t;

  // Mask with the low len bits set; len may be the full word.
  function automatic logic [WORD_MAX-1:0] low_mask(input logic [OFF_W-1:0] len);
    logic [WORD_MAX-1:0] m;
    if (len >= OFF_W'(WORD_MAX)) begin
      m = '1;
    end else begin
      m = (WORD_MAX'(1) << len) - WORD_MAX'(1);
    end
    return m;
  endfunction

  // Index of the highest set bit, zero when no bit is set.
  function automatic logic [HI_W-1:0] msb_index(input logic [WORD_MAX-1:0] v);
    logic [HI_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_MAX; i++) begin
      if (v[i]) begin
        idx = HI_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== design/bea_ram.sv =====
// Bitmap word memory with one write port and one registered read port.
`timescale 1ns / 1ps

module bea_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bea_word_unit.sv =====
// Shared word unit: builds a bit-range mask, finds the highest used bit in it and merges it.
`timescale 1ns / 1ps

module bea_word_unit (
  input  logic [bea_pkg::WORD_MAX-1:0] word,
  input  logic [bea_pkg::OFF_W-1:0]    off,
  input  logic [bea_pkg::OFF_W-1:0]    len,
  output bea_pkg::unit_out_t           res
);

  logic [bea_pkg::WORD_MAX-1:0] mask;
  logic [bea_pkg::WORD_MAX-1:0] used;

  // The caller keeps off + len within one word.
  assign mask = bea_pkg::low_mask(len) << off;
  assign used = word & mask;

  always_comb begin
    res.merged = word | mask;
    res.hit    = |used;
    res.hi     = bea_pkg::msb_index(used);
  end

endmodule

// ===== design/bitmap_extent_allocator.sv =====
// Top level of the bitmap extent allocator: command sequencer, registers and bitmap memory.
//
// One word of the bitmap is handled per cycle by a single shared word unit, except that a
// used block restarting the run inside a word holds the scan on that word. After reset a
// clearing pass writes every bitmap word with busy high. Write word answers without leaving
// the idle state, read word passes through S_RD, and format walks S_FMT over every word.
// An allocation checks its count in S_CHECK, walks S_LOCATE over the words below the data
// start to find the first word, scans in S_EVAL with a restart at each used block, then
// marks the run through S_MARK_RD and S_MARK_WR. The result is shown for one cycle with done
// high and cannot be held off by the receiver.
`timescale 1ns / 1ps

module bitmap_extent_allocator #(
  parameter int MAX_BLOCKS = bea_pkg::MAX_BLOCKS_DEF,
  parameter int WORD_BITS  = bea_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [bea_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action,
  input  logic [5:0]                  word_index,
  input  logic [63:0]                 word_data,
  input  logic [12:0]                 req_blocks,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [11:0]                 alloc_base,
  output logic [63:0]                 read_data
);

  localparam int NUM_WORDS = MAX_BLOCKS / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int WIW       = $clog2(NUM_WORDS + 2);
  localparam int BW_MIN    = $clog2(MAX_BLOCKS + 1);
  localparam int BW        = (BW_MIN > bea_pkg::CFG_W) ? BW_MIN : bea_pkg::CFG_W;
  localparam int OW        = bea_pkg::OFF_W;
  localparam logic [OW-1:0]  WB_OFF   = OW'(WORD_BITS);
  localparam logic [BW-1:0]  WB_BLK   = BW'(WORD_BITS);
  localparam logic [BW-1:0]  MAX_BLK  = BW'(MAX_BLOCKS);
  localparam logic [WIW-1:0] LAST_WI  = WIW'(NUM_WORDS - 1);
  localparam logic [WIW-1:0] NWORDS   = WIW'(NUM_WORDS);
  localparam logic [bea_pkg::HI_W-1:0] TOP_BIT = bea_pkg::HI_W'(WORD_BITS - 1);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_FMT     = 8'b0000_0010,
    S_RD      = 8'b0000_0100,
    S_CHECK   = 8'b0000_1000,
    S_LOCATE  = 8'b0001_0000,
    S_EVAL    = 8'b0010_0000,
    S_MARK_RD = 8'b0100_0000,
    S_MARK_WR = 8'b1000_0000
  } state_t;

  state_t state;

  logic [bea_pkg::CFG_W-1:0] data_base;
  logic [bea_pkg::CFG_W-1:0] dev_blocks;

  logic [WIW-1:0]            wi;
  logic [BW-1:0]             base;
  logic [OW-1:0]             off;
  logic [BW-1:0]             need;
  logic [BW-1:0]             s_blk;
  logic [WIW-1:0]            sw;
  logic [OW-1:0]             so;
  logic [bea_pkg::COUNT_W-1:0] count_r;
  logic [BW-1:0]             limit;
  logic [BW-1:0]             lim_r;
  logic                      clearing;
  logic                      rd_ok;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [WORD_BITS-1:0]      ram_wdata;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [WORD_BITS-1:0]      ram_rdata;

  logic [bea_pkg::WORD_MAX-1:0] unit_word;
  logic [OW-1:0]             unit_off;
  logic [OW-1:0]             unit_len;
  bea_pkg::unit_out_t        unit_res;

  logic [BW-1:0]             ds_ext;
  logic [BW-1:0]             tot_ext;
  logic [BW-1:0]             end_blk;
  logic [BW-1:0]             avail;
  logic [BW-1:0]             count_ext;
  logic [BW-1:0]             base_step;
  logic [BW-1:0]             fmt_rem;
  logic [OW-1:0]             fmt_len;
  logic [OW-1:0]             word_left;
  logic [OW-1:0]             take;
  logic                      fits;
  logic [WIW-1:0]            wi_inc;
  logic                      idx_ok;
  logic [AW-1:0]             idx_addr;
  logic                      accept;
  logic                      past_end;
  logic                      locate_step;
  logic                      eval_adv;
  logic [BW-1:0]             s_new;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  assign ds_ext    = BW'(data_base);
  assign tot_ext   = BW'(dev_blocks);
  assign end_blk   = (tot_ext < MAX_BLK) ? tot_ext : MAX_BLK;
  assign avail     = (end_blk > ds_ext) ? (end_blk - ds_ext) : '0;
  assign count_ext = BW'(count_r);
  assign base_step = base + WB_BLK;
  assign wi_inc    = wi + WIW'(1);

  assign idx_ok    = (32'(word_index) < 32'(NUM_WORDS));
  assign idx_addr  = AW'(word_index);

  // Length of the run still to check or mark that falls in the current word.
  assign word_left = WB_OFF - off;
  assign fits      = (need <= BW'(word_left));
  assign take      = fits ? OW'(need) : word_left;

  assign fmt_rem   = (lim_r > base) ? (lim_r - base) : '0;
  assign fmt_len   = (fmt_rem >= WB_BLK) ? WB_OFF : OW'(fmt_rem);

  assign past_end    = (s_blk > limit);
  assign locate_step = (base_step <= ds_ext);
  assign s_new       = base + BW'(unit_res.hi) + BW'(1);

  // Words past the last full bitmap word count as fully used.
  always_comb begin
    unit_word = '0;
    unit_off  = off;
    unit_len  = take;
    if (state == S_FMT) begin
      unit_off = '0;
      unit_len = fmt_len;
    end else if (wi < NWORDS) begin
      unit_word = bea_pkg::WORD_MAX'(ram_rdata);
    end else begin
      unit_word = bea_pkg::WORD_MAX'({WORD_BITS{1'b1}});
    end
  end

  assign eval_adv = !past_end &&
                    ((!unit_res.hit && !fits) || (unit_res.hit && unit_res.hi == TOP_BIT));

  bea_word_unit u_unit (
    .word (unit_word),
    .off  (unit_off),
    .len  (unit_len),
    .res  (unit_res)
  );

  bea_ram #(
    .DEPTH (NUM_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(wi);
    ram_wdata = unit_res.merged[WORD_BITS-1:0];
    ram_re    = 1'b0;
    ram_raddr = AW'(wi);
    case (state)
      S_IDLE: begin
        if (accept && action == bea_pkg::ACT_WRITE && idx_ok) begin
          ram_we    = 1'b1;
          ram_waddr = idx_addr;
          ram_wdata = word_data[WORD_BITS-1:0];
        end
        if (accept && action == bea_pkg::ACT_READ) begin
          ram_re    = 1'b1;
          ram_raddr = idx_addr;
        end
      end
      S_FMT: begin
        ram_we = 1'b1;
      end
      S_LOCATE: begin
        ram_re = !locate_step;
      end
      S_EVAL: begin
        ram_re    = eval_adv;
        ram_raddr = AW'(wi_inc);
      end
      S_MARK_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(sw);
      end
      S_MARK_WR: begin
        ram_we    = 1'b1;
        ram_re    = !fits;
        ram_raddr = AW'(wi_inc);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_base  <= '0;
      dev_blocks <= bea_pkg::CFG_W'(4096);
    end else if (cfg_write) begin
      case (cfg_index)
        bea_pkg::CFG_DATA_BASE:  data_base  <= cfg_data;
        bea_pkg::CFG_DEV_BLOCKS: dev_blocks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_FMT;
      clearing <= 1'b1;
      lim_r    <= '0;
      wi       <= '0;
      base     <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            status     <= bea_pkg::ST_OK;
            alloc_base <= '0;
            read_data  <= '0;
            count_r    <= req_blocks;
            case (action)
              bea_pkg::ACT_FORMAT: begin
                lim_r    <= (ds_ext < end_blk) ? ds_ext : end_blk;
                clearing <= 1'b0;
                wi       <= '0;
                base     <= '0;
                state    <= S_FMT;
              end
              bea_pkg::ACT_WRITE: begin
                done <= 1'b1;
              end
              bea_pkg::ACT_READ: begin
                rd_ok <= idx_ok;
                state <= S_RD;
              end
              bea_pkg::ACT_ALLOC: begin
                state <= S_CHECK;
              end
              default: begin
              end
            endcase
          end
        end

        S_FMT: begin
          wi   <= wi_inc;
          base <= base_step;
          if (wi == LAST_WI) begin
            done     <= !clearing;
            clearing <= 1'b0;
            state    <= S_IDLE;
          end
        end

        S_RD: begin
          read_data <= rd_ok ? 64'(ram_rdata) : '0;
          done      <= 1'b1;
          state     <= S_IDLE;
        end

        S_CHECK: begin
          if (count_r == '0) begin
            status <= bea_pkg::ST_INVALID;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (count_ext > avail) begin
            status <= bea_pkg::ST_NOSPACE;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            limit <= end_blk - count_ext;
            s_blk <= ds_ext;
            need  <= count_ext;
            wi    <= '0;
            base  <= '0;
            state <= S_LOCATE;
          end
        end

        // Walk to the word that holds the data start, one word per cycle.
        S_LOCATE: begin
          if (locate_step) begin
            base <= base_step;
            wi   <= wi_inc;
          end else begin
            off   <= OW'(ds_ext - base);
            sw    <= wi;
            so    <= OW'(ds_ext - base);
            state <= S_EVAL;
          end
        end

        // A used block inside the candidate run restarts the run just above it.
        S_EVAL: begin
          if (past_end) begin
            status <= bea_pkg::ST_NOSPACE;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (!unit_res.hit) begin
            if (fits) begin
              wi    <= sw;
              off   <= so;
              need  <= count_ext;
              state <= S_MARK_RD;
            end else begin
              need <= need - BW'(word_left);
              wi   <= wi_inc;
              base <= base_step;
              off  <= '0;
            end
          end else begin
            s_blk <= s_new;
            need  <= count_ext;
            if (unit_res.hi == TOP_BIT) begin
              wi   <= wi_inc;
              base <= base_step;
              off  <= '0;
              sw   <= wi_inc;
              so   <= '0;
            end else begin
              off <= OW'(unit_res.hi) + OW'(1);
              sw  <= wi;
              so  <= OW'(unit_res.hi) + OW'(1);
            end
          end
        end

        S_MARK_RD: begin
          state <= S_MARK_WR;
        end

        S_MARK_WR: begin
          if (fits) begin
            alloc_base <= s_blk[11:0];
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            need <= need - BW'(word_left);
            wi   <= wi_inc;
            off  <= '0;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/bea_checker.sv =====
// Port-level checker for the bitmap extent allocator, bound to the top level.
`timescale 1ns / 1ps

module bea_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  action,
  input logic [12:0] req_blocks,
  input logic        done,
  input logic [1:0]  status,
  input logic [11:0] alloc_base,
  input logic [63:0] read_data
);

  // The clearing pass starts right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("block not busy after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word shown while still busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != bea_pkg::ST_OK |-> alloc_base == '0 && read_data == '0)
    else $error("failed allocation carries nonzero fields");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action == bea_pkg::ACT_WRITE |=> done && status == bea_pkg::ST_OK)
    else $error("write word did not complete in one cycle");

  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action == bea_pkg::ACT_ALLOC && req_blocks == '0
    |=> ##1 done && status == bea_pkg::ST_INVALID)
    else $error("zero count allocation not rejected");

endmodule

bind bitmap_extent_allocator bea_checker u_bea_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .action     (action),
  .req_blocks (req_blocks),
  .done       (done),
  .status     (status),
  .alloc_base (alloc_base),
  .read_data  (read_data)
);

// ===== tb/sv/bitmap_extent_allocator_tb.sv =====
// Self-checking testbench for the bitmap extent allocator: directed and random words.
`timescale 1ns / 1ps

module bitmap_extent_allocator_tb;
  import bea_pkg::*;

  localparam int MAX_BLOCKS = MAX_BLOCKS_DEF;
  localparam int WORD_BITS  = WORD_BITS_DEF;
  localparam int NUM_WORDS  = MAX_BLOCKS / WORD_BITS;

  typedef struct packed {
    action_t     action;
    logic [5:0]  widx;
    logic [63:0] wdata;
    logic [12:0] count;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [11:0] first;
    logic [63:0] rdata;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_DATA_BASE;
  logic [12:0] cfg_data = '0;
  logic        start = 1'b0;
  logic [1:0]  action = ACT_FORMAT;
  logic [5:0]  word_index = '0;
  logic [63:0] word_data = '0;
  logic [12:0] req_blocks = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [11:0] alloc_base;
  logic [63:0] read_data;

  bitmap_extent_allocator u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .word_index (word_index),
    .word_data  (word_data),
    .req_blocks (req_blocks),
    .done       (done),
    .status     (status),
    .alloc_base (alloc_base),
    .read_data  (read_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the allocator state.
  logic [WORD_BITS-1:0] shadow_map [NUM_WORDS];
  logic [12:0]          shadow_data_base = 13'd0;
  logic [12:0]          shadow_total = 13'd4096;

  cmd_t     cmd_q[$];
  outcome_t outcome_q[$];
  cmd_t     cur_cmd;
  outcome_t want;

  int mismatches = 0;
  int n_format = 0, n_write = 0, n_read = 0, n_alloc = 0;
  int n_ok = 0, n_invalid = 0, n_nospace = 0, n_settings = 0;
  int burst_left = 1, gap_left = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic int scan_limit();
    return (shadow_total < MAX_BLOCKS) ? int'(shadow_total) : MAX_BLOCKS;
  endfunction

  function automatic int data_area();
    int lim;
    lim = scan_limit();
    return (lim > int'(shadow_data_base)) ? lim - int'(shadow_data_base) : 0;
  endfunction

  function automatic void format_map();
    int lim;
    lim = scan_limit();
    if (int'(shadow_data_base) < lim) lim = int'(shadow_data_base);
    for (int w = 0; w < NUM_WORDS; w++) shadow_map[w] = '0;
    for (int b = 0; b < lim; b++) shadow_map[b / WORD_BITS][b % WORD_BITS] = 1'b1;
  endfunction

  // First fit: the run counter restarts at every used block.
  function automatic void alloc_run(input logic [12:0] count, output status_t st,
                                    output logic [11:0] first);
    int lim, cand_base, run_len, b;
    bit found;
    lim = scan_limit();
    st = ST_NOSPACE;
    first = '0;
    cand_base = 0;
    run_len = 0;
    found = 1'b0;
    if (count == 0) begin
      st = ST_INVALID;
    end else if (int'(count) <= data_area()) begin
      for (b = int'(shadow_data_base); b < lim && !found; b++) begin
        if (!shadow_map[b / WORD_BITS][b % WORD_BITS]) begin
          if (run_len == 0) cand_base = b;
          run_len++;
          if (run_len == int'(count)) found = 1'b1;
        end else begin
          run_len = 0;
        end
      end
      if (found) begin
        for (int k = cand_base; k < cand_base + int'(count); k++)
          shadow_map[k / WORD_BITS][k % WORD_BITS] = 1'b1;
        st = ST_OK;
        first = cand_base[11:0];
      end
    end
  endfunction

  function automatic outcome_t predict_result(input cmd_t c);
    outcome_t o;
    status_t  st;
    logic [11:0] fb;
    o.status = ST_OK;
    o.first = '0;
    o.rdata = '0;
    case (c.action)
      ACT_FORMAT: format_map();
      ACT_WRITE: if (c.widx < NUM_WORDS) shadow_map[c.widx] = c.wdata[WORD_BITS-1:0];
      ACT_READ: if (c.widx < NUM_WORDS) o.rdata = 64'(shadow_map[c.widx]);
      default: begin
        alloc_run(c.count, st, fb);
        o.status = st;
        o.first = fb;
      end
    endcase
    return o;
  endfunction

  // Driver: sends queued words in bursts separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      burst_left = $urandom_range(1, 8);
      gap_left = 0;
    end else if (!start || !busy) begin
      if (start) outcome_q.push_back(predict_result(cur_cmd));
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        cur_cmd = cmd_q.pop_front();
        action <= cur_cmd.action;
        word_index <= cur_cmd.widx;
        word_data <= cur_cmd.wdata;
        req_blocks <= cur_cmd.count;
        start <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 99) < 20) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 8);
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: gap_left = $urandom_range(1, 3);
            6, 7, 8: gap_left = $urandom_range(4, 15);
            default: gap_left = $urandom_range(16, 60);
          endcase
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done !== 1'b0) begin
      if (outcome_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, status %0d", status));
      end else begin
        want = outcome_q.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
        if (alloc_base !== want.first)
          report_mismatch($sformatf("alloc_base %0d, predicted %0d", alloc_base,
                                    want.first));
        if (read_data !== want.rdata)
          report_mismatch($sformatf("read_data %h, predicted %h", read_data, want.rdata));
        case (want.status)
          ST_OK: n_ok++;
          ST_INVALID: n_invalid++;
          default: n_nospace++;
        endcase
      end
    end
  end

  task automatic push_cmd(input action_t a, input int idx, input logic [63:0] d,
                          input int cnt);
    cmd_t c;
    c.action = a;
    c.widx = idx[5:0];
    c.wdata = d;
    c.count = cnt[12:0];
    cmd_q.push_back(c);
    case (a)
      ACT_FORMAT: n_format++;
      ACT_WRITE: n_write++;
      ACT_READ: n_read++;
      default: n_alloc++;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_q.size() != 0 || start || outcome_q.size() != 0 || busy !== 1'b0);
  endtask

  task automatic set_config(input logic [12:0] ds, input logic [12:0] tot);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_DATA_BASE;
    cfg_data <= ds;
    @(posedge clk);
    cfg_index <= CFG_DEV_BLOCKS;
    cfg_data <= tot;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_data_base = ds;
    shadow_total = tot;
    n_settings++;
    @(negedge clk);
  endtask

  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2, 3: return '1;
      4, 5: return {$urandom, $urandom};
      6, 7: return (64'hFFFF_FFFF_FFFF_FFFF >> $urandom_range(0, 63)) << $urandom_range(0, 63);
      default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  function automatic int random_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 8) return $urandom_range(0, 8191);
    if (r < 12) return data_area() + $urandom_range(0, 1);
    if (r < 70) return $urandom_range(1, 16);
    if (r < 90) return $urandom_range(17, 200);
    return $urandom_range(201, 1024);
  endfunction

  task automatic run_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) push_cmd(ACT_FORMAT, $urandom_range(0, 63), random_word(), random_count());
      else if (r < 24) push_cmd(ACT_WRITE, $urandom_range(0, 63), random_word(), 0);
      else if (r < 44) push_cmd(ACT_READ, $urandom_range(0, 63), random_word(), 0);
      else push_cmd(ACT_ALLOC, $urandom_range(0, 63), random_word(), random_count());
    end
  endtask

  // Each new setting opens with a format, allocations at the edge of the data area, a read and a second format.
  task automatic run_phase(input logic [12:0] ds, input logic [12:0] tot, input int n);
    wait_idle();
    set_config(ds, tot);
    push_cmd(ACT_FORMAT, 0, '0, 0);
    push_cmd(ACT_ALLOC, 0, '0, data_area() + 1);
    push_cmd(ACT_ALLOC, 0, '0, 1);
    push_cmd(ACT_READ, (ds / WORD_BITS) % NUM_WORDS, '0, 0);
    push_cmd(ACT_ALLOC, 0, '0, data_area());
    push_cmd(ACT_FORMAT, 0, '0, 0);
    run_random(n);
  endtask

  initial begin
    int ds_r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words at the reset setting, on the cleared bitmap.
    push_cmd(ACT_READ, 0, '0, 0);
    push_cmd(ACT_READ, 63, '1, 0);
    push_cmd(ACT_ALLOC, 0, '0, 0);
    push_cmd(ACT_ALLOC, 0, '0, 4097);
    push_cmd(ACT_ALLOC, 0, '0, 8191);
    push_cmd(ACT_ALLOC, 0, '0, 4096);
    push_cmd(ACT_READ, 63, '0, 0);
    push_cmd(ACT_ALLOC, 0, '0, 1);
    push_cmd(ACT_FORMAT, 0, '0, 0);
    push_cmd(ACT_READ, 0, '0, 0);
    push_cmd(ACT_WRITE, 0, 64'hAAAA_AAAA_AAAA_AAAA, 0);
    push_cmd(ACT_ALLOC, 0, '0, 1);
    push_cmd(ACT_ALLOC, 0, '0, 2);
    push_cmd(ACT_WRITE, 2, 64'h8000_0000_0000_0001, 0);
    push_cmd(ACT_WRITE, 63, '1, 0);
    push_cmd(ACT_WRITE, 5, 64'hFFFF_FFFF_0000_0001, 0);
    push_cmd(ACT_ALLOC, 0, '0, 64);
    push_cmd(ACT_ALLOC, 0, '0, 100);
    push_cmd(ACT_READ, 0, '0, 0);
    push_cmd(ACT_READ, 1, '0, 0);
    push_cmd(ACT_READ, 2, '0, 0);
    push_cmd(ACT_ALLOC, 0, '0, 3777);
    push_cmd(ACT_READ, 62, '0, 0);
    push_cmd(ACT_WRITE, 63, '0, 0);
    push_cmd(ACT_ALLOC, 0, '0, 64);
    run_random(180);

    run_phase(13'd128, 13'd4096, 200);
    run_phase(13'd0, 13'd0, 90);
    run_phase(13'd4096, 13'd4096, 90);
    run_phase(13'd8191, 13'd8191, 90);
    run_phase(13'd1000, 13'd8191, 230);
    run_phase(13'd37, 13'd300, 230);
    run_phase(13'd200, 13'd100, 90);
    run_phase(13'd4095, 13'd4096, 80);
    ds_r = $urandom_range(0, 4096);
    run_phase(ds_r[12:0], 13'($urandom_range(ds_r, 4096)), 230);

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Covered %0d formats, %0d word writes, %0d word reads, %0d allocations",
             n_format, n_write, n_read, n_alloc);
    $display("Outcomes: %0d ok, %0d invalid, %0d no space over %0d settings; %0d mismatches",
             n_ok, n_invalid, n_nospace, n_settings, mismatches);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("Timeout with %0d results outstanding", outcome_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
